@@ hdl/tka_pkg.sv @@
// ----------------------------------------------------------------------------
// tka_pkg
// Shared types and codes for the task key allocator table.
// ----------------------------------------------------------------------------
`default_nettype none

package tka_pkg;

  // Field widths fixed by the command interface
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int TASK_IN_W = 6;
  localparam int KEY_IN_W  = 6;
  localparam int VALUE_IO_W = 32;

  // Command codes
  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SET    = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOKEY  = 2'd1,
    ST_UNUSED = 2'd2
  } status_t;

endpackage : tka_pkg

`default_nettype wire

@@ hdl/task_key_allocator_table.sv @@
// ----------------------------------------------------------------------------
// task_key_allocator_table
// Key allocator with a LIFO free list and a per-task value table.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result appears
// one cycle after the accepting clock edge, on status/key_out/value_out for one
// cycle with done high, and must be taken then. Each command first reads the
// key memory (at the free-list head for a create), valid-row memory and value
// memory at the command's address, then updates them through their single
// write port and registers the result. A new command may be accepted in the
// cycle its predecessor's result is shown. After reset the block runs an
// initialization sweep over the key and valid-row memories, one key per cycle,
// with busy high. A create clears a key's values for all tasks at once by
// zeroing that key's row of per-task valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module task_key_allocator_table #(
  parameter int NUM_KEYS   = 64,
  parameter int NUM_TASKS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [tka_pkg::KIND_W-1:0]        kind,
  input  wire logic [tka_pkg::TASK_IN_W-1:0]     task_req,
  input  wire logic [tka_pkg::KEY_IN_W-1:0]      key_in,
  input  wire logic [tka_pkg::VALUE_IO_W-1:0]    value_in,
  output logic                                   done,
  output logic [tka_pkg::STATUS_W-1:0]           status,
  output logic [tka_pkg::KEY_IN_W-1:0]           key_out,
  output logic [tka_pkg::VALUE_IO_W-1:0]         value_out
);

  localparam int KEY_W   = $clog2(NUM_KEYS);
  localparam int TASK_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int KDEPTH  = 1 << KEY_W;
  localparam int VDEPTH  = 1 << (TASK_W + KEY_W);
  localparam int KWORD_W = KEY_W + 2;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  // Key memory word: in-use mark, end-of-list mark, free-list successor
  typedef struct packed {
    logic             used;
    logic             last;
    logic [KEY_W-1:0] link;
  } key_word_t;

  // Memories
  logic [KWORD_W-1:0]    key_mem [KDEPTH];
  logic [NUM_TASKS-1:0]  row_mem [KDEPTH];
  logic [VALUE_BITS-1:0] val_mem [VDEPTH];

  // Sequencer and list state
  state_t                state;
  logic [KEY_W-1:0]      clr_idx;
  logic [KEY_W-1:0]      free_head;
  logic                  free_nonempty;

  // Latched command
  tka_pkg::kind_t        kind_q;
  logic [TASK_W-1:0]     task_q;
  logic [KEY_W-1:0]      key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic                  key_ok_q;
  logic                  task_ok_q;

  // Registered read data
  key_word_t             key_rd;
  logic [NUM_TASKS-1:0]  row_rd;
  logic [VALUE_BITS-1:0] val_rd;

  // Read address and write controls
  logic                  accept;
  logic [KEY_W-1:0]      task_key_idx;
  logic [TASK_W-1:0]     task_idx;
  logic [KEY_W-1:0]      key_raddr;
  logic                  key_we;
  logic [KEY_W-1:0]      key_waddr;
  key_word_t             key_wdata;
  logic                  row_we;
  logic [KEY_W-1:0]      row_waddr;
  logic [NUM_TASKS-1:0]  row_wdata;
  logic                  val_we;
  logic                  cmd_ok;
  key_word_t             clr_word;
  logic                  clr_edge;

  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign task_key_idx = KEY_W'(key_in);
  assign task_idx = TASK_W'(task_req);

  // Pick the key memory read address: the list head for create
  assign key_raddr = (tka_pkg::kind_t'(kind) == tka_pkg::KIND_CREATE) ? free_head
                                                                      : task_key_idx;

  // Command is legal on a used key (delete, set) or a nonempty list (create)
  assign cmd_ok = (kind_q == tka_pkg::KIND_CREATE) ? free_nonempty
                                                   : (key_ok_q && key_rd.used);

  // Build the reset image of one key entry during the sweep
  always_comb begin
    clr_edge       = (clr_idx == '0) || (clr_idx == KEY_W'(NUM_KEYS - 1));
    clr_word.used  = (clr_idx == '0);
    clr_word.last  = clr_edge;
    clr_word.link  = clr_edge ? '0 : KEY_W'(clr_idx + 1'b1);
  end

  // Select write port contents for the sweep or the executing command
  always_comb begin
    key_we    = 1'b0;
    key_waddr = key_q;
    key_wdata = key_rd;
    row_we    = 1'b0;
    row_waddr = key_q;
    row_wdata = row_rd;
    val_we    = 1'b0;
    case (state)
      S_CLEAR: begin
        key_we    = 1'b1;
        key_waddr = clr_idx;
        key_wdata = clr_word;
        row_we    = 1'b1;
        row_waddr = clr_idx;
        row_wdata = '0;
      end
      S_EXEC: begin
        case (kind_q)
          tka_pkg::KIND_CREATE: begin
            key_we         = cmd_ok;
            key_waddr      = free_head;
            key_wdata.used = 1'b1;
            row_we         = cmd_ok;
            row_waddr      = free_head;
            row_wdata      = '0;
          end
          tka_pkg::KIND_DELETE: begin
            key_we         = cmd_ok;
            key_wdata.used = 1'b0;
            key_wdata.last = !free_nonempty;
            key_wdata.link = free_head;
          end
          tka_pkg::KIND_SET: begin
            row_we              = cmd_ok && task_ok_q;
            row_wdata[task_q]   = 1'b1;
            val_we              = cmd_ok && task_ok_q;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Key memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rd <= key_word_t'(key_mem[key_raddr]);
  end

  // Valid-row memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_waddr] <= row_wdata;
    end
    row_rd <= row_mem[task_key_idx];
  end

  // Value memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[{task_q, key_q}] <= value_q;
    end
    val_rd <= val_mem[{task_idx, task_key_idx}];
  end

  // Latch the command fields on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q    <= tka_pkg::kind_t'(kind);
      task_q    <= task_idx;
      key_q     <= task_key_idx;
      value_q   <= VALUE_BITS'(value_in);
      key_ok_q  <= (32'(key_in) < NUM_KEYS);
      task_ok_q <= (32'(task_req) < NUM_TASKS);
    end
  end

  // Sequencer, free list head and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      free_head     <= KEY_W'(1);
      free_nonempty <= 1'b1;
      done          <= 1'b0;
      status        <= tka_pkg::ST_OK;
      key_out       <= '0;
      value_out     <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= KEY_W'(clr_idx + 1'b1);
          if (clr_idx == KEY_W'(NUM_KEYS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state     <= S_IDLE;
          done      <= 1'b1;
          status    <= tka_pkg::ST_OK;
          key_out   <= '0;
          value_out <= '0;
          case (kind_q)
            tka_pkg::KIND_CREATE: begin
              if (!free_nonempty) begin
                status <= tka_pkg::ST_NOKEY;
              end else begin
                key_out <= tka_pkg::KEY_IN_W'(free_head);
                if (key_rd.last) begin
                  free_nonempty <= 1'b0;
                end else begin
                  free_head <= key_rd.link;
                end
              end
            end
            tka_pkg::KIND_DELETE: begin
              if (!cmd_ok) begin
                status <= tka_pkg::ST_UNUSED;
              end else begin
                free_head     <= key_q;
                free_nonempty <= 1'b1;
              end
            end
            tka_pkg::KIND_GET: begin
              if (key_ok_q && task_ok_q && row_rd[task_q]) begin
                value_out <= tka_pkg::VALUE_IO_W'(val_rd);
              end
            end
            default: begin
              if (!cmd_ok) begin
                status <= tka_pkg::ST_UNUSED;
              end
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Check result timing and result encoding
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result strobe without an executed item");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("one item produced two results");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != tka_pkg::ST_OK)) |-> ((key_out == '0) && (value_out == '0)))
    else $error("failed item carries a key or value");

  a_nokey_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == tka_pkg::ST_NOKEY)) |-> !free_nonempty)
    else $error("no-key status while the free list holds keys");

  a_busy_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (busy && !done))
    else $error("item taken during the initialization sweep");

endmodule : task_key_allocator_table

`default_nettype wire
